// File: hw/rtl/tofhm_pkg.sv
package tofhm_pkg;

	// Frame store geometry
	localparam int FRAME_PIXELS = 76800;
	localparam int ADDR_W       = (FRAME_PIXELS > 1) ? $clog2(FRAME_PIXELS) : 1;

	// Distance must stay below this to count as a valid return
	localparam logic [15:0] DIST_LIMIT = 16'd64000;

	// Queue between classifier and merge unit (power of two, at least 2)
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// Configuration register indexes
	typedef enum logic [1:0] {
		REG_HDR_ENABLE    = 2'd0,
		REG_HDR_FRAMES    = 2'd1,
		REG_MIN_AMPLITUDE = 2'd2,
		REG_MAX_AMPLITUDE = 2'd3
	} reg_idx_t;

	// What the merge unit does with one pixel
	typedef enum logic [1:0] {
		OP_PASS  = 2'd0,  // no store access, emit input as is
		OP_FIRST = 2'd1,  // first frame of a set: overwrite store
		OP_MERGE = 2'd2   // later frame: keep the stronger return
	} op_t;

	typedef struct packed {
		logic        merge_en;
		logic [3:0]  hdr_frames;
		logic [15:0] min_amplitude;
		logic [15:0] max_amplitude;
	} cfg_t;

	typedef struct packed {
		logic [15:0] distance;
		logic [15:0] amp;
	} pix_t;

	typedef struct packed {
		op_t               op;
		logic              emit;
		logic              fend;
		logic [ADDR_W-1:0] addr;
		pix_t              pix;
	} item_t;

	// Validity test applied to every emitted pixel
	function automatic logic pixel_ok(pix_t p, cfg_t c);
		logic amp_ok;
		amp_ok = (p.amp >= c.min_amplitude) && (p.amp < c.max_amplitude);
		return (p.distance != 16'd0) && (p.distance < DIST_LIMIT) && amp_ok;
	endfunction

endpackage

// File: hw/rtl/tofhm_front.sv
module tofhm_front
	import tofhm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [15:0] pixel_distance,
	input  logic [15:0] pixel_amplitude,
	input  logic        frame_end,
	output logic        push_valid,
	input  logic        push_ready,
	output item_t       push_item
);

	logic [3:0]        phase_q;
	logic [ADDR_W-1:0] idx_q;
	logic              active;
	logic [3:0]        pos;
	logic              last;
	logic              in_xfer;

	// Set position of the current frame
	assign active  = cfg.merge_en && (cfg.hdr_frames > 4'd1);
	assign pos     = (phase_q == 4'd0) ? 4'd1 : phase_q;
	assign last    = (pos >= cfg.hdr_frames);
	assign in_ready   = push_ready;
	assign push_valid = in_valid;
	assign in_xfer    = in_valid && in_ready;

	// Classify the pixel for the merge unit
	always_comb begin
		push_item.addr         = idx_q;
		push_item.fend         = frame_end;
		push_item.pix.distance = pixel_distance;
		push_item.pix.amp      = pixel_amplitude;
		if (!active) begin
			push_item.op   = OP_PASS;
			push_item.emit = 1'b1;
		end else begin
			push_item.op   = (phase_q == 4'd0) ? OP_FIRST : OP_MERGE;
			push_item.emit = last;
		end
	end

	// Set phase and raster index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= 4'd0;
			idx_q   <= '0;
		end else if (in_xfer) begin
			if (active && frame_end) begin
				phase_q <= last ? 4'd0 : pos + 4'd1;
			end
			if (frame_end) begin
				idx_q <= '0;
			end else if (idx_q < ADDR_W'(FRAME_PIXELS - 1)) begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	a_idx_restart: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer && frame_end |=> idx_q == '0)
		else $error("pixel index not restarted after frame end");

	a_pass_emits: assert property (@(posedge clk) disable iff (!arst_n)
		push_valid && !active |-> push_item.op == OP_PASS && push_item.emit)
		else $error("pixel held back while merging is off");

endmodule

// File: hw/rtl/tofhm_fifo.sv
module tofhm_fifo
	import tofhm_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push_valid,
	output logic  push_ready,
	input  item_t push_item,
	output logic  pop_valid,
	input  logic  pop_ready,
	output item_t pop_item
);

	item_t             slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wptr_q;
	logic [QPTR_W-1:0] rptr_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              push;
	logic              pop;

	assign push_ready = (cnt_q != QCNT_W'(QUEUE_DEPTH));
	assign pop_valid  = (cnt_q != '0);
	assign pop_item   = slot_q[rptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	// Entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wptr_q] <= push_item;
		end
	end

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) wptr_q <= wptr_q + 1'b1;
			if (pop)  rptr_q <= rptr_q + 1'b1;
			if (push && !pop)      cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

// File: hw/rtl/tofhm_back.sv
module tofhm_back
	import tofhm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	input  logic        pop_valid,
	output logic        pop_ready,
	input  item_t       pop_item,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] out_distance,
	output logic [15:0] out_amplitude,
	output logic        pixel_valid,
	output logic        out_frame_end
);

	pix_t  mem_q [FRAME_PIXELS];
	pix_t  rd_s1;
	pix_t  fwd_pix_s1;
	logic  fwd_s1;
	item_t item_s1;
	logic  valid_s1;
	logic  out_valid_q;
	pix_t  out_pix_q;
	logic  out_ok_q;
	logic  out_fend_q;

	logic  out_adv;
	logic  s1_adv;
	logic  pop;
	logic  mem_we;
	pix_t  stored;
	pix_t  merged;
	pix_t  emit_pix;
	logic  take_new;

	// Stage handshake: s1 moves on when the output register can take it
	assign out_adv   = !out_valid_q || out_ready;
	assign s1_adv    = valid_s1 && out_adv;
	assign pop_ready = !valid_s1 || out_adv;
	assign pop       = pop_valid && pop_ready;

	// Stored pixel, bypassing a write that raced the read
	assign stored = fwd_s1 ? fwd_pix_s1 : rd_s1;

	// Read-modify-write decision
	always_comb begin
		take_new = (item_s1.pix.amp > stored.amp) &&
			(item_s1.pix.amp < cfg.max_amplitude) &&
			(item_s1.pix.distance != 16'd0) && (item_s1.pix.distance < DIST_LIMIT);
		unique case (item_s1.op)
			OP_FIRST: merged = (item_s1.pix.amp >= cfg.max_amplitude) ? '0 : item_s1.pix;
			OP_MERGE: merged = take_new ? item_s1.pix : stored;
			default:  merged = item_s1.pix;
		endcase
		emit_pix = (item_s1.op == OP_PASS) ? item_s1.pix : merged;
	end

	assign mem_we = s1_adv && (item_s1.op != OP_PASS);

	// Frame store: one read port on entry to s1, one write port on exit
	always_ff @(posedge clk) begin
		if (pop) begin
			rd_s1 <= mem_q[pop_item.addr];
		end
		if (mem_we) begin
			mem_q[item_s1.addr] <= merged;
		end
	end

	// s1 payload and bypass data
	always_ff @(posedge clk) begin
		if (pop) begin
			item_s1    <= pop_item;
			fwd_pix_s1 <= merged;
		end
	end

	// s1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			fwd_s1   <= 1'b0;
		end else if (pop_ready) begin
			valid_s1 <= pop_valid;
			fwd_s1   <= pop_valid && mem_we && (item_s1.addr == pop_item.addr);
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_adv) begin
			out_valid_q <= s1_adv && item_s1.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (out_adv && s1_adv && item_s1.emit) begin
			out_pix_q  <= emit_pix;
			out_ok_q   <= pixel_ok(emit_pix, cfg);
			out_fend_q <= item_s1.fend;
		end
	end

	assign out_valid     = out_valid_q;
	assign out_distance  = out_pix_q.distance;
	assign out_amplitude = out_pix_q.amp;
	assign pixel_valid   = out_ok_q;
	assign out_frame_end = out_fend_q;

	a_no_write_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ready |-> !mem_we)
		else $error("frame store written while output stalled");

	a_fwd_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		fwd_s1 |-> valid_s1 && item_s1.op != OP_PASS)
		else $error("bypass set without a store access in s1");

endmodule

// File: hw/rtl/tof_hdr_pixel_merge.sv
// ToF HDR pixel merge. Pixels enter in raster order and leave with a validity flag
// (distance in 1..63999, amplitude in [min_amplitude, max_amplitude)). With HDR merging
// enabled and hdr_frames above one, the first frame of each set fills the frame store
// (saturated pixels zeroed), later frames keep the stronger valid return, and merged pixels
// appear only during the last frame of the set; otherwise every pixel passes straight
// through. The block takes one pixel per clock unless out_ready stalls it, limited by the
// single-read, single-write frame store (76800 x 32 bits) that each pixel reads on entry to
// the merge stage and writes on exit; pixels pass the queue and s1 to the output register. The
// store needs no clearing after reset. Configuration writes take effect at once and
// belong only in gaps with no pixel in flight.
module tof_hdr_pixel_merge
	import tofhm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [15:0] pixel_distance,
	input  logic [15:0] pixel_amplitude,
	input  logic        frame_end,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] out_distance,
	output logic [15:0] out_amplitude,
	output logic        pixel_valid,
	output logic        out_frame_end
);

	cfg_t  cfg_q;
	logic  push_valid;
	logic  push_ready;
	item_t push_item;
	logic  pop_valid;
	logic  pop_ready;
	item_t pop_item;

	assign cfg_ready = 1'b1;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.merge_en      <= 1'b0;
			cfg_q.hdr_frames    <= 4'd0;
			cfg_q.min_amplitude <= 16'd0;
			cfg_q.max_amplitude <= 16'd2000;
		end else if (cfg_valid && cfg_ready) begin
			unique case (reg_idx_t'(cfg_index))
				REG_HDR_ENABLE:    cfg_q.merge_en      <= cfg_data[0];
				REG_HDR_FRAMES:    cfg_q.hdr_frames    <= cfg_data[3:0];
				REG_MIN_AMPLITUDE: cfg_q.min_amplitude <= cfg_data;
				REG_MAX_AMPLITUDE: cfg_q.max_amplitude <= cfg_data;
			endcase
		end
	end

	tofhm_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg_q),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.pixel_distance (pixel_distance),
		.pixel_amplitude(pixel_amplitude),
		.frame_end      (frame_end),
		.push_valid     (push_valid),
		.push_ready     (push_ready),
		.push_item      (push_item)
	);

	tofhm_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_item (push_item),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_item  (pop_item)
	);

	tofhm_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.pop_valid    (pop_valid),
		.pop_ready    (pop_ready),
		.pop_item     (pop_item),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_distance (out_distance),
		.out_amplitude(out_amplitude),
		.pixel_valid  (pixel_valid),
		.out_frame_end(out_frame_end)
	);

endmodule
